// ===== src/mlci_pkg.sv =====
// Package: shared types and constants of the shaded line rasterizer.
`default_nettype none
package mlci_pkg;
    localparam int IMAGE_SIZE_DEF      = 64;
    localparam int COLOR_FRAC_BITS_DEF = 16;
    localparam int COORD_W             = 6;
    localparam int LEN_W               = 7;
    localparam int DEC_W               = 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic advance;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic zero_len;
        logic div_done;
        logic last_pix;
    } status_t;
endpackage
`default_nettype wire

// ===== src/mlci_ctrl.sv =====
// Controller: sequences setup, color-step division and pixel emission.
`default_nettype none
module mlci_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic             out_fire,
    input  wire mlci_pkg::status_t sts,
    output mlci_pkg::cmd_t        cmd,
    output logic                  in_ready,
    output logic                  out_valid
);
    import mlci_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.zero_len)
                    state_next = ST_IDLE;
                else if (sts.div_done)
                    state_next = ST_EMIT;
                else
                    cmd.div_step = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                begin
                    cmd.advance = 1'b1;
                    if (sts.last_pix)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_fire) |=> state_reg == ST_DIV)
        else $error("setup did not follow an accepted segment");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && sts.last_pix) |=> in_ready)
        else $error("block not idle after the final pixel");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides busy at once");
endmodule
`default_nettype wire

// ===== src/mlci_dp.sv =====
// Datapath: midpoint stepping, restoring color-step divider and accumulators.
`default_nettype none
module mlci_dp #(
    parameter int IMAGE_SIZE      = mlci_pkg::IMAGE_SIZE_DEF,
    parameter int COLOR_FRAC_BITS = mlci_pkg::COLOR_FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mlci_pkg::cmd_t                 cmd,
    input  wire logic [mlci_pkg::COORD_W-1:0]   x_start,
    input  wire logic [mlci_pkg::COORD_W-1:0]   y_start,
    input  wire logic [mlci_pkg::COORD_W-1:0]   x_end,
    input  wire logic [mlci_pkg::COORD_W-1:0]   y_end,
    input  wire logic [7:0]                     start_red,
    input  wire logic [7:0]                     start_green,
    input  wire logic [7:0]                     start_blue,
    input  wire logic [7:0]                     end_red,
    input  wire logic [7:0]                     end_green,
    input  wire logic [7:0]                     end_blue,
    output mlci_pkg::status_t                   sts,
    output logic [mlci_pkg::COORD_W-1:0]        pixel_x,
    output logic [mlci_pkg::COORD_W-1:0]        pixel_y,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue,
    output logic                                last
);
    import mlci_pkg::*;

    localparam int QW   = 8 + COLOR_FRAC_BITS;     // quotient width
    localparam int ACCW = QW + 2;                  // signed accumulator
    localparam int CW   = $clog2(QW + 1);
    localparam logic [COORD_W-1:0] MAXC = COORD_W'(IMAGE_SIZE - 1);

    function automatic logic [COORD_W-1:0] sat(input logic [COORD_W-1:0] v);
        return (v > MAXC) ? MAXC : v;
    endfunction

    function automatic logic [7:0] cout(input logic signed [ACCW-1:0] a);
        logic signed [ACCW-1:0] r;
        r = (a + (ACCW'(1) <<< (COLOR_FRAC_BITS - 1))) >>> COLOR_FRAC_BITS;
        if (a < 0)
            return 8'd0;
        else if (r > 255)
            return 8'd255;
        else
            return r[7:0];
    endfunction

    logic [COORD_W-1:0]       x1, y1, x2, y2;
    logic [COORD_W-1:0]       adx, ady;
    logic                     ymaj_c;

    logic [COORD_W-1:0]       major_reg, minor_reg;
    logic signed [DEC_W-1:0]  dec_reg;
    logic [LEN_W-1:0]         steps_reg;
    logic [3:0]               mode_reg;
    logic [COORD_W-1:0]       len_reg, mnr_reg;
    logic [2:0][7:0]          diff_reg;
    logic [2:0]               neg_reg;
    logic [2:0][ACCW-1:0]     acc_reg;
    logic [2:0][QW-1:0]       quo_reg;
    logic [2:0][COORD_W:0]    rem_reg;
    logic [CW-1:0]            cnt_reg;
    logic                     zero_reg;

    logic [2:0][7:0]          c0, c1;
    logic                     mv;

    assign x1 = sat(x_start);
    assign y1 = sat(y_start);
    assign x2 = sat(x_end);
    assign y2 = sat(y_end);
    assign adx = (x2 >= x1) ? x2 - x1 : x1 - x2;
    assign ady = (y2 >= y1) ? y2 - y1 : y1 - y2;
    assign ymaj_c = ady > adx;
    assign c0 = {start_blue, start_green, start_red};
    assign c1 = {end_blue, end_green, end_red};

    assign mv = mode_reg[3] ? (dec_reg >= 0) : (dec_reg > 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_reg <= '0;
            minor_reg <= '0;
            dec_reg   <= '0;
            steps_reg <= '0;
            mode_reg  <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            zero_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            zero_reg  <= (adx == '0) && (ady == '0);
            len_reg   <= ymaj_c ? ady : adx;
            mnr_reg   <= ymaj_c ? adx : ady;
            major_reg <= ymaj_c ? y1 : x1;
            minor_reg <= ymaj_c ? x1 : y1;
            dec_reg   <= DEC_W'({1'b0, (ymaj_c ? adx : ady), 1'b0})
                       - DEC_W'(ymaj_c ? ady : adx);
            steps_reg <= LEN_W'(ymaj_c ? ady : adx) + LEN_W'(1);
            mode_reg  <= {(adx != '0) && (ady != '0) &&
                              (ymaj_c == ((x2 > x1) == (y2 > y1))),
                          ymaj_c ? (x2 < x1) : (y2 < y1),
                          ymaj_c ? (y2 < y1) : (x2 < x1),
                          ymaj_c};
            for (int i = 0; i < 3; i++)
            begin
                diff_reg[i] <= (c1[i] >= c0[i]) ? c1[i] - c0[i] : c0[i] - c1[i];
                neg_reg[i]  <= c1[i] < c0[i];
                acc_reg[i]  <= ACCW'(c0[i]) << COLOR_FRAC_BITS;
                rem_reg[i]  <= '0;
            end
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            // One quotient bit per cycle, MSB first, of diff * 2^F / len.
            for (int i = 0; i < 3; i++)
            begin
                logic [COORD_W+1:0] t;
                logic [QW-1:0]      num;
                num = {diff_reg[i], COLOR_FRAC_BITS'(0)};
                t = {rem_reg[i], num[QW - 1 - 32'(cnt_reg)]};
                if (t >= {2'b00, len_reg})
                begin
                    rem_reg[i] <= (COORD_W+1)'(t - {2'b00, len_reg});
                    quo_reg[i] <= {quo_reg[i][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= (COORD_W+1)'(t);
                    quo_reg[i] <= {quo_reg[i][QW-2:0], 1'b0};
                end
            end
            cnt_reg <= cnt_reg + CW'(1);
        end
        else if (cmd.advance)
        begin
            steps_reg <= steps_reg - LEN_W'(1);
            if (steps_reg != LEN_W'(1))
            begin
                if (mv)
                begin
                    minor_reg <= mode_reg[2] ? minor_reg - 1'b1 : minor_reg + 1'b1;
                    dec_reg   <= dec_reg + DEC_W'({1'b0, mnr_reg, 1'b0})
                               - DEC_W'({1'b0, len_reg, 1'b0});
                end
                else
                    dec_reg <= dec_reg + DEC_W'({1'b0, mnr_reg, 1'b0});
                major_reg <= mode_reg[1] ? major_reg - 1'b1 : major_reg + 1'b1;
                for (int i = 0; i < 3; i++)
                    acc_reg[i] <= neg_reg[i] ? acc_reg[i] - ACCW'(quo_reg[i])
                                             : acc_reg[i] + ACCW'(quo_reg[i]);
            end
        end
    end

    assign sts.zero_len = zero_reg;
    assign sts.div_done = cnt_reg == CW'(QW);
    assign sts.last_pix = steps_reg == LEN_W'(1);

    assign pixel_x = mode_reg[0] ? minor_reg : major_reg;
    assign pixel_y = mode_reg[0] ? major_reg : minor_reg;
    assign red     = cout(acc_reg[0]);
    assign green   = cout(acc_reg[1]);
    assign blue    = cout(acc_reg[2]);
    assign last    = sts.last_pix;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> steps_reg != '0)
        else $error("pixel emitted with no steps left");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> cnt_reg < CW'(QW))
        else $error("divider stepped past its width");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |=> $stable(len_reg))
        else $error("major length changed during emission");
endmodule
`default_nettype wire

// ===== src/midpoint_line_color_interp_core.sv =====
// Top level: shaded midpoint line rasterizer.
//
//  channel | dir | tdata fields (low bit first)
//  s_axis  | in  | x_start y_start x_end y_end start_rgb end_rgb (72 bits)
//  m_axis  | out | pixel_x pixel_y red green blue (36 bits in 40), tlast=last
//
// A segment is loaded, passes through the bit-serial color-step divider, then
// emits one pixel per cycle while m_axis_tready is high (up to 64 pixels).
// A zero-length segment returns to idle from the divider state with no output.
// rst_n clears all control state asynchronously.
// m_axis_tready low holds the current pixel; one segment is handled at a time.
`default_nettype none
module midpoint_line_color_interp_core #(
    parameter int IMAGE_SIZE      = mlci_pkg::IMAGE_SIZE_DEF,
    parameter int COLOR_FRAC_BITS = mlci_pkg::COLOR_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x_start[5:0] y_start[11:6] x_end[17:12] y_end[23:18] start r,g,b end r,g,b
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pixel_x[5:0] pixel_y[11:6] red[19:12] green[27:20] blue[35:28], zero fill
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    import mlci_pkg::*;

    cmd_t    cmd;
    status_t sts;
    logic [COORD_W-1:0] px, py;
    logic [7:0] r, g, b;

    mlci_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && s_axis_tready),
        .out_fire(m_axis_tvalid && m_axis_tready),
        .sts(sts), .cmd(cmd),
        .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
    );

    mlci_dp #(.IMAGE_SIZE(IMAGE_SIZE), .COLOR_FRAC_BITS(COLOR_FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .x_start(s_axis_tdata[5:0]),   .y_start(s_axis_tdata[11:6]),
        .x_end(s_axis_tdata[17:12]),   .y_end(s_axis_tdata[23:18]),
        .start_red(s_axis_tdata[31:24]), .start_green(s_axis_tdata[39:32]),
        .start_blue(s_axis_tdata[47:40]), .end_red(s_axis_tdata[55:48]),
        .end_green(s_axis_tdata[63:56]), .end_blue(s_axis_tdata[71:64]),
        .sts(sts), .pixel_x(px), .pixel_y(py),
        .red(r), .green(g), .blue(b), .last(m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, b, g, r, py, px};
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the shaded midpoint line rasterizer core.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int FRAC = 16;
    localparam int NUM_ITEMS = 310;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [7:0] end_blue;
        logic [7:0] end_green;
        logic [7:0] end_red;
        logic [7:0] start_blue;
        logic [7:0] start_green;
        logic [7:0] start_red;
        logic [5:0] y_end;
        logic [5:0] x_end;
        logic [5:0] y_start;
        logic [5:0] x_start;
    } segment_t;

    typedef struct packed {
        logic       last;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [5:0] pixel_y;
        logic [5:0] pixel_x;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    segment_t segment_queue[$];
    pixel_t   pixel_queue[$];
    int       error_count;
    int       cycle_count;
    bit       stim_done;
    bit       hold_sender;
    bit       in_taken;
    int       burst_left;
    int       gap_left;
    int       stall_phase;

    midpoint_line_color_interp_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [7:0] round_color(longint acc);
        longint r;
        if (acc < 0)
            return 8'd0;
        r = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic longint shade_step(int c0, int c1, int len);
        longint diff;
        longint mag;
        diff = (c1 >= c0) ? c1 - c0 : c0 - c1;
        mag = (diff <<< FRAC) / len;
        return (c1 >= c0) ? mag : -mag;
    endfunction

    // Walks the segment and appends every pixel it should produce.
    task automatic rasterize_segment(segment_t seg);
        int dx, dy, adx, ady, len, mnr, maj_dir, min_dir, maj, mnp, e, k;
        bit ymaj, tie, mv;
        int c0[3], c1[3];
        longint acc[3], stp[3];
        pixel_t p;
        dx = int'(seg.x_end) - int'(seg.x_start);
        dy = int'(seg.y_end) - int'(seg.y_start);
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        if (adx == 0 && ady == 0)
            return;
        c0[0] = seg.start_red;  c0[1] = seg.start_green;  c0[2] = seg.start_blue;
        c1[0] = seg.end_red;    c1[1] = seg.end_green;    c1[2] = seg.end_blue;
        ymaj = ady > adx;
        len = ymaj ? ady : adx;
        mnr = ymaj ? adx : ady;
        maj_dir = ymaj ? (dy < 0 ? -1 : 1) : (dx < 0 ? -1 : 1);
        min_dir = ymaj ? (dx < 0 ? -1 : 1) : (dy < 0 ? -1 : 1);
        tie = (dx != 0 && dy != 0) && (ymaj == ((dx > 0) == (dy > 0)));
        maj = ymaj ? seg.y_start : seg.x_start;
        mnp = ymaj ? seg.x_start : seg.y_start;
        e = 2 * mnr - len;
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = longint'(c0[i]) <<< FRAC;
            stp[i] = shade_step(c0[i], c1[i], len);
        end
        for (k = 0; k <= len; k++)
        begin
            p.pixel_x = ymaj ? mnp[5:0] : maj[5:0];
            p.pixel_y = ymaj ? maj[5:0] : mnp[5:0];
            p.red = round_color(acc[0]);
            p.green = round_color(acc[1]);
            p.blue = round_color(acc[2]);
            p.last = (k == len);
            pixel_queue.push_back(p);
            mv = tie ? (e >= 0) : (e > 0);
            if (mv)
            begin
                mnp += min_dir;
                e += 2 * (mnr - len);
            end
            else
                e += 2 * mnr;
            maj += maj_dir;
            for (int i = 0; i < 3; i++)
                acc[i] += stp[i];
        end
    endtask

    function automatic segment_t random_segment();
        segment_t seg;
        int len;
        seg = 72'({$urandom, $urandom, $urandom});
        // Mostly short segments keep the run quick; a few span the image.
        if ($urandom_range(0, 9) != 0)
        begin
            len = $urandom_range(0, 12);
            seg.x_end = 6'(int'(seg.x_start) + $urandom_range(0, 2 * len) - len);
            seg.y_end = 6'(int'(seg.y_start) + $urandom_range(0, 2 * len) - len);
            if ($urandom_range(0, 7) == 0)
                seg.y_end = seg.y_start;
            else if ($urandom_range(0, 7) == 0)
                seg.x_end = seg.x_start;
        end
        return seg;
    endfunction

    function automatic segment_t make_segment(int x0, int y0, int x1, int y1,
                                              logic [23:0] c0, logic [23:0] c1);
        segment_t seg;
        seg.x_start = 6'(x0);  seg.y_start = 6'(y0);
        seg.x_end = 6'(x1);    seg.y_end = 6'(y1);
        {seg.start_blue, seg.start_green, seg.start_red} = c0;
        {seg.end_blue, seg.end_green, seg.end_red} = c1;
        return seg;
    endfunction

    initial
    begin
        // Extremes, each octant, horizontal, vertical, diagonal and zero length.
        segment_queue.push_back(make_segment(0, 0, 63, 63, 24'h000000, 24'hffffff));
        segment_queue.push_back(make_segment(63, 63, 0, 0, 24'hffffff, 24'h000000));
        segment_queue.push_back(make_segment(0, 5, 63, 5, 24'h00ff00, 24'hff00ff));
        segment_queue.push_back(make_segment(7, 63, 7, 0, 24'h123456, 24'hfedcba));
        segment_queue.push_back(make_segment(10, 10, 10, 10, 24'hffffff, 24'h000000));
        segment_queue.push_back(make_segment(0, 0, 0, 0, 24'h000000, 24'h000000));
        segment_queue.push_back(make_segment(10, 10, 20, 14, 24'h0a1020, 24'h20100a));
        segment_queue.push_back(make_segment(10, 10, 14, 20, 24'h808080, 24'h7f7f7f));
        segment_queue.push_back(make_segment(10, 10, 0, 14, 24'hff0000, 24'h00ff00));
        segment_queue.push_back(make_segment(10, 10, 6, 20, 24'h0000ff, 24'hff0000));
        segment_queue.push_back(make_segment(10, 10, 0, 6, 24'h00ff00, 24'h0000ff));
        segment_queue.push_back(make_segment(10, 10, 6, 0, 24'h010101, 24'hfefefe));
        segment_queue.push_back(make_segment(10, 10, 20, 6, 24'hfefefe, 24'h010101));
        segment_queue.push_back(make_segment(10, 10, 14, 0, 24'h55aa55, 24'haa55aa));
        segment_queue.push_back(make_segment(0, 0, 2, 1, 24'h000000, 24'hffffff));
        segment_queue.push_back(make_segment(0, 0, 1, 2, 24'hffffff, 24'h000000));
        segment_queue.push_back(make_segment(2, 1, 0, 0, 24'h000000, 24'hffffff));
        segment_queue.push_back(make_segment(63, 0, 0, 63, 24'h3c3c3c, 24'hc3c3c3));
        segment_queue.push_back(make_segment(0, 0, 1, 0, 24'h00ff00, 24'hff00ff));
        segment_queue.push_back(make_segment(0, 62, 63, 1, 24'hffffff, 24'hfffffe));
        for (int i = 0; i < NUM_ITEMS - 20; i++)
            segment_queue.push_back(random_segment());
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Sender: random bursts and gaps, plus one hold until all pixels drain.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_taken)
            begin
                // Current transaction still waiting; keep it.
            end
            else if (segment_queue.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                stim_done <= 1'b1;
            end
            else if (segment_queue.size() == NUM_ITEMS / 2 && !hold_sender
                     && pixel_queue.size() != 0)
                s_axis_tvalid <= 1'b0;
            else if (gap_left > 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else
            begin
                if (segment_queue.size() == NUM_ITEMS / 2)
                    hold_sender <= 1'b1;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= segment_queue.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    burst_left <= burst_left - 1;
            end
            stall_phase <= stall_phase + 1;
            // Receiver: periodic stall windows with a random component.
            m_axis_tready <= (stall_phase % 97 < 30) ? 1'b1
                           : ((stall_phase % 11) < 3 ? 1'b0 : ($urandom_range(0, 3) != 0));
        end
    end

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            // The sender looks at this flag to know the last transaction was taken.
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                rasterize_segment(segment_t'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tlast, m_axis_tdata[35:0]};
                if (pixel_queue.size() == 0)
                begin
                    $display("%0t: unexpected pixel %h", $realtime, got);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected x=%0d y=%0d rgb=%h%h%h last=%b",
                                 $realtime, want.pixel_x, want.pixel_y,
                                 want.red, want.green, want.blue, want.last);
                        $display("%0t: actual   x=%0d y=%0d rgb=%h%h%h last=%b",
                                 $realtime, got.pixel_x, got.pixel_y,
                                 got.red, got.green, got.blue, got.last);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        stim_done = 1'b0;
        hold_sender = 1'b0;
        in_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        fork
            begin
                wait (stim_done && !s_axis_tvalid && pixel_queue.size() == 0);
                repeat (100) @(posedge clk);
            end
            begin
                wait (cycle_count >= CYCLE_LIMIT);
                error_count = error_count + 1;
                $display("%0t: timeout", $realtime);
            end
        join_any
        if (error_count == 0)
            $display("** midpoint_line_color_interp_core: PASSED **");
        else
            $display("** midpoint_line_color_interp_core: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
